### rtl/rclt_pkg.sv
package rclt_pkg;

   // row geometry
   localparam int CELLS = 1024;
   localparam int IDX_W = $clog2(CELLS);

   // field widths
   localparam int POS_W  = 11;
   localparam int STEP_W = 11;
   localparam int LEN_W  = IDX_W + 1;
   localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;
   localparam int CNT_W  = IDX_W + 1;

   // reset value of the target length register
   localparam logic [POS_W-1:0] TARGET_RESET = POS_W'(1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MERGE,
      ST_REPLY
   } state_type;

endpackage

### rtl/rclt_ram.sv
module rclt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write one word, read two with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### rtl/rclt_merge.sv
module rclt_merge (
   input  rclt_pkg::idx_type          pos_idx,
   input  logic                       set_left,
   input  logic                       set_right,
   input  rclt_pkg::idx_type          end_left,
   input  rclt_pkg::idx_type          end_right,
   input  logic [rclt_pkg::POS_W-1:0] target_length,
   input  rclt_pkg::cnt_type          count_cur,
   output rclt_pkg::idx_type          run_lo,
   output rclt_pkg::idx_type          run_hi,
   output rclt_pkg::cnt_type          count_next
);
   import rclt_pkg::*;

   idx_type          lo;
   idx_type          hi;
   logic [CMP_W-1:0] tgt;
   logic [CMP_W-1:0] len_left;
   logic [CMP_W-1:0] len_right;
   logic [CMP_W-1:0] len_new;
   cnt_type          cnt_a;
   cnt_type          cnt_b;

   // find the ends of the joined run
   always_comb begin
      lo = set_left  ? end_left  : pos_idx;
      hi = set_right ? end_right : pos_idx;
   end

   // lengths of the old neighbour runs and the new run
   always_comb begin
      tgt       = CMP_W'(target_length);
      len_left  = CMP_W'(pos_idx - lo);
      len_right = CMP_W'(hi - pos_idx);
      len_new   = CMP_W'({1'b0, hi} - {1'b0, lo} + LEN_W'(1));
   end

   // drop absorbed runs, never below zero, then add the new one
   always_comb begin
      cnt_a = count_cur;
      if (set_left && (len_left == tgt) && (cnt_a != '0)) begin
         cnt_a = cnt_a - CNT_W'(1);
      end
      cnt_b = cnt_a;
      if (set_right && (len_right == tgt) && (cnt_b != '0)) begin
         cnt_b = cnt_b - CNT_W'(1);
      end
      count_next = cnt_b;
      if (len_new == tgt) begin
         count_next = cnt_b + CNT_W'(1);
      end
   end

   assign run_lo = lo;
   assign run_hi = hi;

endmodule

### rtl/run_coalescing_length_tracker.sv
// A word taken at a start edge passes through the read, merge and reply states and is shown on
// the rsp_ ports in the reply state, for one cycle, and is taken at the edge that ends that state.
// Busy stays high from each start through the read, merge and reply states, set by the read, merge
// and second endpoint write on the single write port of the endpoint memory; a new word is taken
// only in the idle state. Reset: synchronous, active high; afterwards busy stays high while the cell
// bits are swept clear, one cell at a time. Target length resets to 1. The receiver cannot stall.
module run_coalescing_length_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [rclt_pkg::POS_W-1:0]  req_position,
   input  logic                        csr_we,
   input  logic [rclt_pkg::POS_W-1:0]  csr_wdata,
   output logic                        rsp_valid,
   output logic                        rsp_target_present,
   output logic [rclt_pkg::STEP_W-1:0] rsp_latest_step,
   output logic                        rsp_repeat_flag
);
   import rclt_pkg::*;

   state_type         state_ff, state_in;
   idx_type           clr_ff, clr_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  target_ff, target_in;
   cnt_type           count_ff, count_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] latest_ff, latest_in;
   logic              repeat_ff, repeat_in;
   logic              set_self_ff, set_self_in;
   logic              set_left_ff, set_left_in;
   idx_type           end_left_ff, end_left_in;
   idx_type           end_right_ff, end_right_in;
   idx_type           hi_ff, hi_in;
   idx_type           lo_ff, lo_in;

   idx_type p_req;
   idx_type p_idx;
   logic    has_left;
   logic    has_right;
   logic    pos_ok;
   logic    take;
   logic    set_right;
   idx_type run_lo;
   idx_type run_hi;
   cnt_type count_next;

   // cell bit memory
   logic    bit_we;
   idx_type bit_wa;
   logic    bit_wd;
   idx_type bit_ra_a;
   idx_type bit_ra_b;
   logic    bit_rd_a;
   logic    bit_rd_b;

   // far end memory
   logic    end_we;
   idx_type end_wa;
   idx_type end_wd;
   idx_type end_ra_a;
   idx_type end_ra_b;
   idx_type end_rd_a;
   idx_type end_rd_b;

   // index arithmetic
   always_comb begin
      p_req     = IDX_W'(req_position - POS_W'(1));
      p_idx     = IDX_W'(pos_ff - POS_W'(1));
      has_left  = (p_idx != '0);
      has_right = (p_idx != IDX_W'(CELLS - 1));
      pos_ok    = (pos_ff != '0) && (32'(pos_ff) <= 32'(CELLS));
      take      = pos_ok && !set_self_ff;
      set_right = has_right && bit_rd_a;
   end

   rclt_ram #(.WIDTH(1), .DEPTH(CELLS)) u_bit_ram (
      .clock     (clock),
      .wr_en     (bit_we),
      .wr_addr   (bit_wa),
      .wr_data   (bit_wd),
      .rd_addr_a (bit_ra_a),
      .rd_addr_b (bit_ra_b),
      .rd_data_a (bit_rd_a),
      .rd_data_b (bit_rd_b)
   );

   rclt_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_end_ram (
      .clock     (clock),
      .wr_en     (end_we),
      .wr_addr   (end_wa),
      .wr_data   (end_wd),
      .rd_addr_a (end_ra_a),
      .rd_addr_b (end_ra_b),
      .rd_data_a (end_rd_a),
      .rd_data_b (end_rd_b)
   );

   rclt_merge u_merge (
      .pos_idx       (p_idx),
      .set_left      (set_left_ff),
      .set_right     (set_right),
      .end_left      (end_left_ff),
      .end_right     (end_right_ff),
      .target_length (target_ff),
      .count_cur     (count_ff),
      .run_lo        (run_lo),
      .run_hi        (run_hi),
      .count_next    (count_next)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IDX_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_MERGE;
         ST_MERGE: state_in = ST_REPLY;
         ST_REPLY: state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // memory ports and handshake outputs
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      bit_we    = 1'b0;
      bit_wa    = p_idx;
      bit_wd    = 1'b1;
      bit_ra_a  = p_idx + IDX_W'(1);
      bit_ra_b  = p_idx - IDX_W'(1);
      end_we    = 1'b0;
      end_wa    = run_lo;
      end_wd    = run_hi;
      end_ra_a  = p_req - IDX_W'(1);
      end_ra_b  = p_req + IDX_W'(1);
      case (state_ff)
         ST_CLEAR: begin
            bit_we = 1'b1;
            bit_wa = clr_ff;
            bit_wd = 1'b0;
         end
         ST_IDLE: begin
            busy     = 1'b0;
            bit_ra_a = p_req;
            bit_ra_b = p_req - IDX_W'(1);
         end
         ST_READ: begin
         end
         ST_MERGE: begin
            bit_we = take;
            end_we = take;
         end
         ST_REPLY: begin
            rsp_valid = 1'b1;
            end_we    = repeat_ff == 1'b0;
            end_wa    = hi_ff;
            end_wd    = lo_ff;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      clr_in       = clr_ff;
      pos_in       = pos_ff;
      target_in    = target_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      latest_in    = latest_ff;
      repeat_in    = repeat_ff;
      set_self_in  = set_self_ff;
      set_left_in  = set_left_ff;
      end_left_in  = end_left_ff;
      end_right_in = end_right_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + IDX_W'(1);
      end
      if (state_ff == ST_IDLE && start) begin
         pos_in = req_position;
      end
      // hold the first reads while the right bit comes in
      if (state_ff == ST_READ) begin
         set_self_in  = bit_rd_a;
         set_left_in  = has_left && bit_rd_b;
         end_left_in  = end_rd_a;
         end_right_in = end_rd_b;
      end
      // merge and advance the step
      if (state_ff == ST_MERGE) begin
         repeat_in = !take;
         lo_in     = run_lo;
         hi_in     = run_hi;
         if (take) begin
            count_in = count_next;
            step_in  = step_ff + STEP_W'(1);
            if (count_next != '0) begin
               latest_in = step_ff + STEP_W'(1);
            end
         end
      end
      // a new target drops the count
      if (csr_we) begin
         target_in = csr_wdata;
         count_in  = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         target_ff <= TARGET_RESET;
         count_ff  <= '0;
         step_ff   <= '0;
         latest_ff <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         target_ff <= target_in;
         count_ff  <= count_in;
         step_ff   <= step_in;
         latest_ff <= latest_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      repeat_ff    <= repeat_in;
      set_self_ff  <= set_self_in;
      set_left_ff  <= set_left_in;
      end_left_ff  <= end_left_in;
      end_right_ff <= end_right_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
   end

   assign rsp_target_present = (count_ff != '0);
   assign rsp_latest_step    = latest_ff;
   assign rsp_repeat_flag    = repeat_ff;

endmodule
